>>> rtl/irdu_pkg.sv
// ---------------------------------------------------------------------------
// irdu_pkg
// Shared types, constants and the alphabet lookup for the radix digit unit.
// ---------------------------------------------------------------------------
`default_nettype none

package irdu_pkg;

    localparam int SYM_W         = 8;
    localparam int RADIX_W       = 5;
    localparam int CFG_IDX_W     = 2;
    localparam int CFG_DATA_W    = 64;
    localparam int ALPHABET_SIZE = 16;
    localparam int STEP_BITS     = 8;
    localparam int QUEUE_DEPTH   = 2;

    localparam logic [SYM_W-1:0] SIGN_SYMBOL = 8'h2D;
    localparam logic [SYM_W-1:0] PLUS_SYMBOL = 8'h2B;

    localparam logic [CFG_IDX_W-1:0] CFG_RADIX        = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SYMBOLS_LOW  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_SYMBOLS_HIGH = 2'd2;

    localparam logic [RADIX_W-1:0]    RADIX_RESET        = 5'd10;
    localparam logic [CFG_DATA_W-1:0] SYMBOLS_LOW_RESET  = 64'h3736_3534_3332_3130;
    localparam logic [CFG_DATA_W-1:0] SYMBOLS_HIGH_RESET = 64'h0000_0000_0000_3938;

    typedef struct packed {
        logic [CFG_DATA_W-1:0] symbols_high;
        logic [CFG_DATA_W-1:0] symbols_low;
        logic [RADIX_W-1:0]    radix;
    } alphabet_t;

    typedef enum logic [2:0] {
        BK_IDLE,
        BK_DIV,
        BK_SIGN,
        BK_READ,
        BK_EMIT
    } back_state_t;

    function automatic logic [SYM_W-1:0] symbol_at(
        input logic [CFG_DATA_W-1:0] low,
        input logic [CFG_DATA_W-1:0] high,
        input logic [3:0]            idx
    );
        logic [SYM_W-1:0] s;
        if (idx[3] == 1'b0)
        begin
            s = low[8*idx[2:0] +: SYM_W];
        end
        else
        begin
            s = high[8*idx[2:0] +: SYM_W];
        end
        return s;
    endfunction

endpackage

`default_nettype wire

>>> rtl/irdu_front.sv
// ---------------------------------------------------------------------------
// irdu_front
// Configuration registers, alphabet check and sign/magnitude split of input.
// ---------------------------------------------------------------------------
`default_nettype none

module irdu_front #(
    parameter int MAX_RADIX  = 16,
    parameter int VALUE_BITS = 32
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [irdu_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [irdu_pkg::CFG_DATA_W-1:0] cfg_data,
    input  logic                            in_valid,
    output logic                            in_ready,
    input  logic [VALUE_BITS-1:0]           in_value,
    output logic                            push_valid,
    input  logic                            push_ready,
    output logic                            push_neg,
    output logic [VALUE_BITS-1:0]           push_mag,
    output irdu_pkg::alphabet_t             alphabet
);
    import irdu_pkg::*;

    logic [RADIX_W-1:0]    radix_reg;
    logic [CFG_DATA_W-1:0] low_reg;
    logic [CFG_DATA_W-1:0] high_reg;
    logic                  ok;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            radix_reg <= RADIX_RESET;
            low_reg   <= SYMBOLS_LOW_RESET;
            high_reg  <= SYMBOLS_HIGH_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                CFG_RADIX:        radix_reg <= cfg_data[RADIX_W-1:0];
                CFG_SYMBOLS_LOW:  low_reg   <= cfg_data;
                CFG_SYMBOLS_HIGH: high_reg  <= cfg_data;
                default:          ;
            endcase
        end
    end

    always_comb
    begin
        logic [SYM_W-1:0] si;
        ok = (radix_reg >= RADIX_W'(2)) && (radix_reg <= RADIX_W'(MAX_RADIX));
        for (int i = 0; i < ALPHABET_SIZE; i++)
        begin
            si = symbol_at(low_reg, high_reg, 4'(i));
            if (RADIX_W'(i) < radix_reg)
            begin
                if (si == PLUS_SYMBOL || si == SIGN_SYMBOL)
                begin
                    ok = 1'b0;
                end
                for (int j = i + 1; j < ALPHABET_SIZE; j++)
                begin
                    if (RADIX_W'(j) < radix_reg && symbol_at(low_reg, high_reg, 4'(j)) == si)
                    begin
                        ok = 1'b0;
                    end
                end
            end
        end
    end

    assign in_ready   = push_ready;
    assign push_valid = in_valid && ok;
    assign push_neg   = in_value[VALUE_BITS-1];
    assign push_mag   = push_neg ? (~in_value + VALUE_BITS'(1)) : in_value;

    assign alphabet.radix        = radix_reg;
    assign alphabet.symbols_low  = low_reg;
    assign alphabet.symbols_high = high_reg;

endmodule

`default_nettype wire

>>> rtl/irdu_queue.sv
// ---------------------------------------------------------------------------
// irdu_queue
// Short FIFO between the classifying front and the digit engine.
// ---------------------------------------------------------------------------
`default_nettype none

module irdu_queue #(
    parameter int WIDTH = 33
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_ready,
    input  logic [WIDTH-1:0] in_data,
    output logic             out_valid,
    input  logic             out_ready,
    output logic [WIDTH-1:0] out_data
);
    import irdu_pkg::*;

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    logic [WIDTH-1:0] mem [QUEUE_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [CNT_W-1:0] count_reg;
    logic             push;
    logic             pop;

    assign in_ready  = (count_reg != CNT_W'(QUEUE_DEPTH));
    assign out_valid = (count_reg != '0);
    assign out_data  = mem[rd_ptr_reg];
    assign push      = in_valid && in_ready;
    assign pop       = out_valid && out_ready;

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[wr_ptr_reg] <= in_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0
                                                                      : wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0
                                                                      : rd_ptr_reg + 1'b1;
            end
            case ({push, pop})
                2'b10:   count_reg <= count_reg + 1'b1;
                2'b01:   count_reg <= count_reg - 1'b1;
                default: ;
            endcase
        end
    end

endmodule

`default_nettype wire

>>> rtl/irdu_back.sv
// ---------------------------------------------------------------------------
// irdu_back
// Digit engine: repeated division by the radix into a digit stack, then any
// sign beat and the digits, most significant first, via an output register.
// ---------------------------------------------------------------------------
`default_nettype none

module irdu_back #(
    parameter int MAX_RADIX  = 16,
    parameter int VALUE_BITS = 32
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  irdu_pkg::alphabet_t         alphabet,
    input  logic                        q_valid,
    output logic                        q_ready,
    input  logic                        q_neg,
    input  logic [VALUE_BITS-1:0]       q_mag,
    output logic                        m_valid,
    input  logic                        m_ready,
    output logic [irdu_pkg::SYM_W-1:0]  m_symbol,
    output logic                        m_last
);
    import irdu_pkg::*;

    localparam int MAG_W     = ((VALUE_BITS + STEP_BITS - 1) / STEP_BITS) * STEP_BITS;
    localparam int DIV_STEPS = MAG_W / STEP_BITS;
    localparam int STEP_W    = (DIV_STEPS > 1) ? $clog2(DIV_STEPS) : 1;
    localparam int DIG_W     = $clog2(MAX_RADIX);
    localparam int T_W       = DIG_W + 1;
    localparam int IDX_W     = $clog2(VALUE_BITS);
    localparam int CNT_W     = $clog2(VALUE_BITS + 1);

    back_state_t       state_reg, state_next;
    logic [MAG_W-1:0]  work_reg, work_next;
    logic [DIG_W-1:0]  rem_reg, rem_next;
    logic [STEP_W-1:0] step_reg, step_next;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    logic              neg_reg, neg_next;
    logic              m_valid_reg, m_valid_next;
    logic [SYM_W-1:0]  m_symbol_reg, m_symbol_next;
    logic              m_last_reg, m_last_next;

    logic [DIG_W-1:0]  stack [VALUE_BITS];
    logic [DIG_W-1:0]  rd_data_reg;
    logic              stack_we;
    logic              stack_re;
    logic [CNT_W-1:0]  cnt_dec;

    logic [MAG_W-1:0]  div_w;
    logic [DIG_W-1:0]  div_r;
    logic [T_W-1:0]    rad_t;
    logic              out_free;

    assign rad_t    = T_W'(alphabet.radix);
    assign cnt_dec  = cnt_reg - CNT_W'(1);
    assign out_free = !m_valid_reg || m_ready;

    always_comb
    begin
        logic [T_W-1:0] t;
        div_w = work_reg;
        div_r = rem_reg;
        for (int k = 0; k < STEP_BITS; k++)
        begin
            t     = {div_r, div_w[MAG_W-1]};
            div_w = {div_w[MAG_W-2:0], 1'b0};
            if (t >= rad_t)
            begin
                div_r    = DIG_W'(t - rad_t);
                div_w[0] = 1'b1;
            end
            else
            begin
                div_r = t[DIG_W-1:0];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (stack_we)
        begin
            stack[cnt_reg[IDX_W-1:0]] <= div_r;
        end
        if (stack_re)
        begin
            rd_data_reg <= stack[cnt_dec[IDX_W-1:0]];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= BK_IDLE;
            step_reg    <= '0;
            cnt_reg     <= '0;
            neg_reg     <= 1'b0;
            m_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            step_reg    <= step_next;
            cnt_reg     <= cnt_next;
            neg_reg     <= neg_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        work_reg     <= work_next;
        rem_reg      <= rem_next;
        m_symbol_reg <= m_symbol_next;
        m_last_reg   <= m_last_next;
    end

    always_comb
    begin
        state_next    = state_reg;
        work_next     = work_reg;
        rem_next      = rem_reg;
        step_next     = step_reg;
        cnt_next      = cnt_reg;
        neg_next      = neg_reg;
        m_valid_next  = m_valid_reg && !m_ready;
        m_symbol_next = m_symbol_reg;
        m_last_next   = m_last_reg;
        stack_we      = 1'b0;
        stack_re      = 1'b0;
        q_ready       = 1'b0;

        case (state_reg)
            BK_IDLE:
            begin
                q_ready = 1'b1;
                if (q_valid)
                begin
                    work_next  = MAG_W'(q_mag);
                    rem_next   = '0;
                    step_next  = '0;
                    cnt_next   = '0;
                    neg_next   = q_neg;
                    state_next = BK_DIV;
                end
            end
            BK_DIV:
            begin
                work_next = div_w;
                rem_next  = div_r;
                step_next = step_reg + 1'b1;
                if (step_reg == STEP_W'(DIV_STEPS - 1))
                begin
                    stack_we  = 1'b1;
                    cnt_next  = cnt_reg + 1'b1;
                    step_next = '0;
                    rem_next  = '0;
                    if (div_w == '0)
                    begin
                        state_next = neg_reg ? BK_SIGN : BK_READ;
                    end
                end
            end
            BK_SIGN:
            begin
                if (out_free)
                begin
                    m_valid_next  = 1'b1;
                    m_symbol_next = SIGN_SYMBOL;
                    m_last_next   = 1'b0;
                    state_next    = BK_READ;
                end
            end
            BK_READ:
            begin
                stack_re   = 1'b1;
                state_next = BK_EMIT;
            end
            BK_EMIT:
            begin
                if (out_free)
                begin
                    m_valid_next  = 1'b1;
                    m_symbol_next = symbol_at(alphabet.symbols_low, alphabet.symbols_high,
                                              4'(rd_data_reg));
                    m_last_next   = (cnt_reg == CNT_W'(1));
                    cnt_next      = cnt_dec;
                    state_next    = (cnt_reg == CNT_W'(1)) ? BK_IDLE : BK_READ;
                end
            end
            default:
            begin
                state_next = BK_IDLE;
            end
        endcase
    end

    assign m_valid  = m_valid_reg;
    assign m_symbol = m_symbol_reg;
    assign m_last   = m_last_reg;

    a_stack_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == BK_DIV) |-> (cnt_reg < CNT_W'(VALUE_BITS)))
        else $error("digit stack overflow");

    a_emit_count: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == BK_READ || state_reg == BK_EMIT) |-> (cnt_reg != '0))
        else $error("emit with empty digit stack");

    a_sign_neg: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == BK_SIGN) |-> neg_reg)
        else $error("sign beat for non-negative value");

    a_last_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == BK_EMIT && out_free && cnt_reg == CNT_W'(1))
        |=> (m_valid_reg && m_last_reg && cnt_reg == '0))
        else $error("final digit not marked last");

endmodule

`default_nettype wire

>>> rtl/integer_to_radix_digits_unit.sv
// ---------------------------------------------------------------------------
// integer_to_radix_digits_unit
// Signed integer to digit symbols in a configurable radix and alphabet.
// ---------------------------------------------------------------------------
// Each accepted value is checked against the configured alphabet; with a bad
// alphabet (radix out of 2..MAX_RADIX, a repeated symbol, or '+' / '-' in use)
// the beat is consumed and nothing is sent. Otherwise a '-' beat comes first
// for a negative value, then one beat per digit, most significant first, with
// tlast on the final digit. The digits come from repeated division of the
// magnitude by the radix, eight quotient bits per cycle, into a single-port
// digit stack; each digit is read from it into a register (BK_READ) before
// it is emitted (BK_EMIT). The engine takes no new value until the final
// digit is in the output register; a two-entry queue lets the input side
// take further values while the engine works.
// ---------------------------------------------------------------------------
`default_nettype none

module integer_to_radix_digits_unit #(
    parameter int MAX_RADIX  = 16,
    parameter int VALUE_BITS = 32
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    input  logic [((VALUE_BITS+7)/8)*8-1:0]     s_axis_tdata,  // value
    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    output logic [irdu_pkg::SYM_W-1:0]          m_axis_tdata,  // symbol
    output logic                                m_axis_tlast,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [irdu_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [irdu_pkg::CFG_DATA_W-1:0]     cfg_data
);
    import irdu_pkg::*;

    alphabet_t             alphabet;
    logic                  push_valid;
    logic                  push_ready;
    logic                  push_neg;
    logic [VALUE_BITS-1:0] push_mag;
    logic                  q_valid;
    logic                  q_ready;
    logic [VALUE_BITS:0]   q_data;

    irdu_front #(
        .MAX_RADIX  (MAX_RADIX),
        .VALUE_BITS (VALUE_BITS)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .in_valid   (s_axis_tvalid),
        .in_ready   (s_axis_tready),
        .in_value   (s_axis_tdata[VALUE_BITS-1:0]),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_neg   (push_neg),
        .push_mag   (push_mag),
        .alphabet   (alphabet)
    );

    irdu_queue #(
        .WIDTH (VALUE_BITS + 1)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (push_valid),
        .in_ready  (push_ready),
        .in_data   ({push_neg, push_mag}),
        .out_valid (q_valid),
        .out_ready (q_ready),
        .out_data  (q_data)
    );

    irdu_back #(
        .MAX_RADIX  (MAX_RADIX),
        .VALUE_BITS (VALUE_BITS)
    ) u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .alphabet (alphabet),
        .q_valid  (q_valid),
        .q_ready  (q_ready),
        .q_neg    (q_data[VALUE_BITS]),
        .q_mag    (q_data[VALUE_BITS-1:0]),
        .m_valid  (m_axis_tvalid),
        .m_ready  (m_axis_tready),
        .m_symbol (m_axis_tdata),
        .m_last   (m_axis_tlast)
    );

endmodule

`default_nettype wire

>>> tb/tb.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb
// Self-checking bench for integer_to_radix_digits_unit.
// ---------------------------------------------------------------------------
// A short table of values and register writes runs first. It covers the
// extreme values, radix 2 and 16, alphabets that must be rejected, unused
// alphabet bytes, zero-byte symbols and the ignored register index. Random
// segments follow. Each one loads a fresh alphabet, some of them defective,
// and streams random values under one of four idle and stall profiles.
// Every symbol beat is checked in order against the bench's own digit
// predictor, or against the text typed into the table. Register writes
// happen only once the unit has drained.
// ---------------------------------------------------------------------------
module tb;
    import irdu_pkg::*;

    localparam int VALUE_BITS   = 32;
    localparam int VALUE_W      = ((VALUE_BITS + 7) / 8) * 8;
    localparam int DRAIN_CYCLES = 600;
    localparam int STALL_LIMIT  = 4000;
    localparam int SEGMENTS     = 8;
    localparam int SEG_ITEMS    = 30;
    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;

    logic                  clk           = 1'b0;
    logic                  rst_n         = 1'b0;
    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    logic [VALUE_W-1:0]    s_axis_tdata  = '0;     // value
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    logic [SYM_W-1:0]      m_axis_tdata;           // symbol
    logic                  m_axis_tlast;
    logic                  cfg_valid     = 1'b0;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index     = '0;
    logic [CFG_DATA_W-1:0] cfg_data      = '0;

    logic [RADIX_W-1:0]    model_radix = RADIX_RESET;
    logic [CFG_DATA_W-1:0] model_low   = SYMBOLS_LOW_RESET;
    logic [CFG_DATA_W-1:0] model_high  = SYMBOLS_HIGH_RESET;

    logic [SYM_W-1:0] pending_symbols [$];
    bit               pending_last    [$];

    int err_count  = 0;
    int idle_count = 0;
    int src_idle   = 0;
    int sink_stall = 0;

    bit                    row_is_cfg [$];
    logic [CFG_IDX_W-1:0]  row_index  [$];
    logic [CFG_DATA_W-1:0] row_data   [$];
    bit                    row_typed  [$];
    string                 row_text   [$];

    integer_to_radix_digits_unit #(
        .MAX_RADIX  (16),
        .VALUE_BITS (VALUE_BITS)
    ) u_top (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    function automatic logic [SYM_W-1:0] alphabet_symbol(int i);
        logic [SYM_W-1:0] s;
        if (i < 8)
        begin
            s = model_low[8*i +: SYM_W];
        end
        else
        begin
            s = model_high[8*(i-8) +: SYM_W];
        end
        return s;
    endfunction

    function automatic bit alphabet_accepted();
        int n;
        n = int'(model_radix);
        if (n < 2 || n > 16)
        begin
            return 1'b0;
        end
        for (int i = 0; i < n; i++)
        begin
            if (alphabet_symbol(i) == PLUS_SYMBOL || alphabet_symbol(i) == SIGN_SYMBOL)
            begin
                return 1'b0;
            end
            for (int j = i + 1; j < n; j++)
            begin
                if (alphabet_symbol(j) == alphabet_symbol(i))
                begin
                    return 1'b0;
                end
            end
        end
        return 1'b1;
    endfunction

    task automatic predict_digits(logic [VALUE_BITS-1:0] v);
        int unsigned mag;
        int unsigned base;
        int          digits [$];
        if (!alphabet_accepted())
        begin
            return;
        end
        base = int'(model_radix);
        mag  = v[VALUE_BITS-1] ? -v : v;
        do
        begin
            digits.push_front(mag % base);
            mag = mag / base;
        end
        while (mag != 0);
        if (v[VALUE_BITS-1])
        begin
            pending_symbols.push_back(SIGN_SYMBOL);
            pending_last.push_back(1'b0);
        end
        foreach (digits[k])
        begin
            pending_symbols.push_back(alphabet_symbol(digits[k]));
            pending_last.push_back(k == digits.size() - 1);
        end
    endtask

    task automatic push_text(string text);
        for (int i = 0; i < text.len(); i++)
        begin
            pending_symbols.push_back(text[i]);
            pending_last.push_back(i == text.len() - 1);
        end
    endtask

    task automatic report_mismatch(string what, int got, int want);
        $display("MISMATCH %s: got 0x%0h expected 0x%0h at %0t", what, got, want, $realtime);
        err_count++;
    endtask

    task automatic wait_idle();
        @(negedge clk);
        s_axis_tvalid = 1'b0;
        while (pending_symbols.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
        wait_idle();
        @(negedge clk);
        cfg_valid = 1'b1;
        cfg_index = idx;
        cfg_data  = data;
        do
        begin
            @(posedge clk);
        end
        while (!cfg_ready);
        case (idx)
            CFG_RADIX:        model_radix = data[RADIX_W-1:0];
            CFG_SYMBOLS_LOW:  model_low   = data;
            CFG_SYMBOLS_HIGH: model_high  = data;
            default:          ;
        endcase
        @(negedge clk);
        cfg_valid = 1'b0;
    endtask

    task automatic send_value(logic [VALUE_BITS-1:0] v, bit typed, string text);
        @(negedge clk);
        while ($urandom_range(0, 99) < src_idle)
        begin
            s_axis_tvalid = 1'b0;
            @(negedge clk);
        end
        s_axis_tvalid = 1'b1;
        s_axis_tdata  = VALUE_W'(v);
        do
        begin
            @(posedge clk);
        end
        while (!s_axis_tready);
        if (typed)
        begin
            push_text(text);
        end
        else
        begin
            predict_digits(v);
        end
    endtask

    task automatic add_cfg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
        row_is_cfg.push_back(1'b1);
        row_index.push_back(idx);
        row_data.push_back(data);
        row_typed.push_back(1'b0);
        row_text.push_back("");
    endtask

    task automatic add_val(logic [VALUE_BITS-1:0] v, bit typed, string text);
        row_is_cfg.push_back(1'b0);
        row_index.push_back(CFG_RADIX);
        row_data.push_back(CFG_DATA_W'(v));
        row_typed.push_back(typed);
        row_text.push_back(text);
    endtask

    function automatic logic [VALUE_BITS-1:0] random_value();
        int          sel;
        logic [31:0] v;
        sel = $urandom_range(0, 15);
        case (sel)
            0:       v = 32'h0000_0000;
            1:       v = 32'h7FFF_FFFF;
            2:       v = 32'h8000_0000;
            3:       v = 32'hFFFF_FFFF;
            4, 5, 6, 7, 8:
            begin
                v = $urandom_range(0, 300);
                if ($urandom_range(0, 1) == 1)
                begin
                    v = -v;
                end
            end
            default: v = $urandom;
        endcase
        return v;
    endfunction

    task automatic load_random_alphabet();
        logic [SYM_W-1:0]      syms [16];
        bit                    used [256];
        logic [CFG_DATA_W-1:0] low;
        logic [CFG_DATA_W-1:0] high;
        logic [CFG_DATA_W-1:0] radix_word;
        logic [SYM_W-1:0]      b;
        int                    order [3];
        int                    radix;
        int                    n;
        int                    defect;
        int                    i;
        int                    j;
        int                    t;
        case ($urandom_range(0, 3))
            0:       radix = 2;
            1:       radix = 16;
            default: radix = $urandom_range(2, 16);
        endcase
        defect = $urandom_range(0, 9);
        if (defect == 0)
        begin
            radix = ($urandom_range(0, 1) == 1) ? $urandom_range(0, 1) : $urandom_range(17, 31);
        end
        n = (radix > 16) ? 16 : radix;
        foreach (used[k])
        begin
            used[k] = 1'b0;
        end
        for (i = 0; i < 16; i++)
        begin
            if (i < n)
            begin
                do
                begin
                    b = SYM_W'($urandom_range(0, 255));
                end
                while (used[b] || b == PLUS_SYMBOL || b == SIGN_SYMBOL);
                used[b] = 1'b1;
            end
            else
            begin
                b = SYM_W'($urandom_range(0, 255));
            end
            syms[i] = b;
        end
        if (defect == 1 && n >= 2)
        begin
            j = $urandom_range(1, n - 1);
            i = $urandom_range(0, j - 1);
            syms[j] = syms[i];
        end
        else if (defect == 2 && n >= 1)
        begin
            syms[$urandom_range(0, n - 1)] = ($urandom_range(0, 1) == 1) ? PLUS_SYMBOL : SIGN_SYMBOL;
        end
        for (i = 0; i < 8; i++)
        begin
            low[8*i +: SYM_W]  = syms[i];
            high[8*i +: SYM_W] = syms[i+8];
        end
        radix_word = {$urandom, $urandom};
        radix_word[RADIX_W-1:0] = RADIX_W'(radix);
        order = '{0, 1, 2};
        for (i = 2; i > 0; i--)
        begin
            j = $urandom_range(0, i);
            t = order[i];
            order[i] = order[j];
            order[j] = t;
        end
        if ($urandom_range(0, 3) == 0)
        begin
            write_reg(CFG_UNUSED, {$urandom, $urandom});
        end
        foreach (order[k])
        begin
            case (order[k])
                0:       write_reg(CFG_RADIX, radix_word);
                1:       write_reg(CFG_SYMBOLS_LOW, low);
                default: write_reg(CFG_SYMBOLS_HIGH, high);
            endcase
        end
    endtask

    always @(negedge clk)
    begin
        m_axis_tready = ($urandom_range(0, 99) >= sink_stall);
    end

    always @(posedge clk)
    begin
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            if (pending_symbols.size() == 0)
            begin
                report_mismatch("unexpected symbol beat", int'(m_axis_tdata), 0);
            end
            else
            begin
                if (m_axis_tdata !== pending_symbols[0])
                begin
                    report_mismatch("symbol", int'(m_axis_tdata), int'(pending_symbols[0]));
                end
                if (m_axis_tlast !== pending_last[0])
                begin
                    report_mismatch("last_symbol", int'(m_axis_tlast), int'(pending_last[0]));
                end
                void'(pending_symbols.pop_front());
                void'(pending_last.pop_front());
            end
        end
    end

    always @(posedge clk)
    begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)
            || (cfg_valid && cfg_ready))
        begin
            idle_count <= 0;
        end
        else
        begin
            idle_count <= idle_count + 1;
            if (idle_count >= STALL_LIMIT)
            begin
                $display("Testbench completed WITH ERRORS");
                $finish;
            end
        end
    end

    initial
    begin
        // reset alphabet "0123456789"
        add_val(32'h0000_0000, 1'b1, "0");
        add_val(32'h7FFF_FFFF, 1'b1, "2147483647");
        add_val(32'h8000_0000, 1'b1, "-2147483648");
        add_val(32'hFFFF_FFFF, 1'b1, "-1");
        add_val(32'd12345, 1'b0, "");
        add_cfg(CFG_UNUSED, 64'hFFFF_FFFF_FFFF_FFFF);
        add_val(-32'sd987654321, 1'b0, "");
        // hex alphabet
        add_cfg(CFG_SYMBOLS_HIGH, 64'h4645_4443_4241_3938);
        add_cfg(CFG_RADIX, 64'd16);
        add_val(32'h7FFF_FFFF, 1'b1, "7FFFFFFF");
        add_val(32'h8000_0000, 1'b1, "-80000000");
        add_val(32'hDEAD_BEEF, 1'b0, "");
        // radix 2, upper data bits dropped
        add_cfg(CFG_RADIX, 64'hFFFF_FFFF_FFFF_FFE2);
        add_val(32'h8000_0000, 1'b1, "-10000000000000000000000000000000");
        add_val(32'hFFFF_FFFF, 1'b1, "-1");
        add_val(32'h7FFF_FFFF, 1'b0, "");
        // radix out of range
        add_cfg(CFG_RADIX, 64'd1);
        add_val(32'd5, 1'b1, "");
        add_cfg(CFG_RADIX, 64'd17);
        add_val(32'd5, 1'b1, "");
        add_cfg(CFG_RADIX, 64'd31);
        add_val(32'hFFFF_FFFF, 1'b1, "");
        // repeated symbol in the upper half
        add_cfg(CFG_RADIX, 64'd10);
        add_cfg(CFG_SYMBOLS_HIGH, 64'h0000_0000_0000_3930);
        add_val(32'd7, 1'b1, "");
        add_cfg(CFG_SYMBOLS_HIGH, 64'h0000_0000_0000_3938);
        // unused bytes hold sign and duplicates
        add_cfg(CFG_SYMBOLS_LOW, 64'h2B2D_2B2D_2B63_6261);
        add_cfg(CFG_RADIX, 64'd3);
        add_val(32'd5, 1'b1, "bc");
        add_val(-32'sd5, 1'b1, "-bc");
        add_val(32'd0, 1'b1, "a");
        // plus, then minus, in use
        add_cfg(CFG_SYMBOLS_LOW, 64'h0000_0000_002B_6261);
        add_val(32'd5, 1'b1, "");
        add_cfg(CFG_SYMBOLS_LOW, 64'h0000_0000_002D_6261);
        add_val(32'd5, 1'b1, "");
        // zero-byte symbol
        add_cfg(CFG_SYMBOLS_LOW, 64'h0000_0000_0000_0100);
        add_cfg(CFG_RADIX, 64'd2);
        add_val(32'd6, 1'b0, "");
        add_val(32'hFFFF_FFFF, 1'b0, "");

        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        foreach (row_is_cfg[r])
        begin
            if (row_is_cfg[r])
            begin
                write_reg(row_index[r], row_data[r]);
            end
            else
            begin
                send_value(row_data[r][VALUE_BITS-1:0], row_typed[r], row_text[r]);
            end
        end

        for (int seg = 0; seg < SEGMENTS; seg++)
        begin
            load_random_alphabet();
            case (seg % 4)
                0:       begin src_idle = 0;  sink_stall = 0;  end
                1:       begin src_idle = 72; sink_stall = 0;  end
                2:       begin src_idle = 0;  sink_stall = 72; end
                default: begin src_idle = 17; sink_stall = 17; end
            endcase
            for (int k = 0; k < SEG_ITEMS; k++)
            begin
                send_value(random_value(), 1'b0, "");
            end
            wait_idle();
            src_idle   = 0;
            sink_stall = 0;
        end

        wait_idle();
        if (err_count == 0)
        begin
            $display("Testbench completed without errors");
        end
        else
        begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule
